// ===== rtl/core/shpp_pkg.sv =====
// Shared types and constants for the sensor-hub packet parser.
// Holds the input and result item structs, the result kind codes and header constants.
// No dependencies.
package shpp_pkg;

  typedef enum logic [2:0] {
    KIND_NULL_HEADER = 3'd0,
    KIND_BAD_LENGTH  = 3'd1,
    KIND_PRODUCT_ID  = 3'd2,
    KIND_ERROR_DONE  = 3'd3,
    KIND_ERROR_ENTRY = 3'd4,
    KIND_MAG_REPORT  = 3'd5,
    KIND_OTHER       = 3'd6
  } kind_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         channel;
    logic [7:0]         reset_cause;
    logic [3:0]         error_index;
    logic [7:0]         error_code;
    logic [4:0]         error_count;
    logic [1:0]         mag_accuracy;
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_y;
    logic signed [15:0] mag_z;
  } out_item_t;

  localparam logic [15:0] RAW_LEN_INVALID   = 16'hFFFF;
  localparam logic [14:0] HEADER_BYTES      = 15'd4;
  localparam logic [14:0] MAG_MIN_PAYLOAD   = 15'd15;
  localparam logic [14:0] PROD_MIN_PAYLOAD  = 15'd2;
  localparam logic [14:0] MAX_PAYLOAD_RESET = 15'd300;

  localparam logic [7:0] CH_ERROR   = 8'd0;
  localparam logic [7:0] CH_PRODUCT = 8'd2;
  localparam logic [7:0] CH_REPORT  = 8'd3;

  localparam logic [7:0] RID_PRODUCT_ID_RESP = 8'hF8;
  localparam logic [7:0] RID_ERROR_LIST      = 8'h01;
  localparam logic [7:0] RID_TIMEBASE        = 8'hFB;
  localparam logic [7:0] SUB_MAG_CALIBRATED  = 8'h03;

  // Payload byte positions with a fixed meaning.
  localparam logic [14:0] POS_RESET_CAUSE = 15'd1;
  localparam logic [14:0] POS_SUB_REPORT  = 15'd5;
  localparam logic [14:0] POS_ACCURACY    = 15'd7;
  localparam logic [14:0] POS_AXIS_FIRST  = 15'd9;
  localparam logic [14:0] POS_AXIS_LAST   = 15'd14;

endpackage

// ===== rtl/core/sensor_hub_packet_parser_top.sv =====
// Top level of the sensor-hub packet parser: header decode, payload field capture and
// result output stage with a one-entry skid. Depends on shpp_pkg.
//
// Takes one received byte per item and decodes sensor-hub packets: the four header
// bytes (length low, length high with the continuation bit masked, channel, sequence),
// then the payload. At most one result item comes out per input item: a null header,
// a bad length, a product-id response, each error-list entry as it arrives and the
// error-list summary, a calibrated magnetometer report, or "other packet". Every input
// item is processed by logic between the parser state registers and the result
// register, so one byte can be accepted every clock while in_ready is high. The result
// register is backed by a skid entry, so input is taken while a result waits; in_ready
// drops only when both are full. The user must write max_payload through
// cfg_we/cfg_wdata only while the block is idle; the block does not enforce it.
module sensor_hub_packet_parser_top #(
  parameter int ERROR_LIST_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [14:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  shpp_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output shpp_pkg::out_item_t out_item
);
  import shpp_pkg::*;

  localparam int CNT_W = $clog2(ERROR_LIST_DEPTH + 1);
  localparam int EXT_W = CNT_W + 5;

  logic [14:0] max_payload;
  logic [14:0] byte_position, byte_position_next;
  logic [14:0] payload_length, payload_length_next;
  logic [7:0]  length_low_byte, length_low_byte_next;
  logic [7:0]  packet_channel, packet_channel_next;
  logic [7:0]  report_id, report_id_next;
  logic [7:0]  sub_report_id, sub_report_id_next;
  logic        ignore_rest, ignore_rest_next;
  logic [7:0]  captured_reset_cause, captured_reset_cause_next;
  logic [CNT_W-1:0] captured_errors, captured_errors_next;
  logic [47:0] axis_accumulator, axis_accumulator_next;
  logic [1:0]  captured_accuracy, captured_accuracy_next;

  logic        accept;
  logic        res_valid;
  out_item_t   res;

  logic [7:0]  b;
  logic [14:0] pos;
  logic [14:0] p;
  logic [15:0] raw;
  logic [14:0] plen;
  logic [14:0] plen_m4;
  logic [2:0]  lane;
  logic        last;
  logic        is_err;
  logic        entry;
  logic [EXT_W-1:0] idx_ext;
  logic [EXT_W-1:0] cnt_ext;

  out_item_t   skid_item;
  logic        skid_valid;

  assign accept = in_valid && in_ready;
  assign in_ready = !skid_valid;
  assign b = in_item.rx_byte;

  always_comb begin
    byte_position_next        = byte_position;
    payload_length_next       = payload_length;
    length_low_byte_next      = length_low_byte;
    packet_channel_next       = packet_channel;
    report_id_next            = report_id;
    sub_report_id_next        = sub_report_id;
    ignore_rest_next          = ignore_rest;
    captured_reset_cause_next = captured_reset_cause;
    captured_errors_next      = captured_errors;
    axis_accumulator_next     = axis_accumulator;
    captured_accuracy_next    = captured_accuracy;
    res_valid = 1'b0;
    res       = '0;
    pos       = in_item.frame_start ? 15'd0 : byte_position;
    p         = pos - HEADER_BYTES;
    raw       = {report_id, length_low_byte};
    plen      = raw[14:0];
    plen_m4   = plen - HEADER_BYTES;
    lane      = 3'(p - POS_AXIS_FIRST);
    last      = ({1'b0, p} + 16'd1) >= {1'b0, payload_length};
    is_err    = 1'b0;
    entry     = 1'b0;
    idx_ext   = '0;
    cnt_ext   = '0;

    if (in_item.frame_start) begin
      byte_position_next = 15'd0;
      ignore_rest_next   = 1'b0;
    end

    if (in_item.frame_start || !ignore_rest) begin
      if (pos < HEADER_BYTES) begin
        byte_position_next = pos + 15'd1;
        case (pos[1:0])
          2'd0: length_low_byte_next = b;
          2'd1: report_id_next = b;
          2'd2: packet_channel_next = b;
          default: begin
            // Fourth header byte: judge the length and maybe finish the packet here.
            report_id_next     = '0;
            sub_report_id_next = '0;
            ignore_rest_next   = 1'b1;
            res.channel        = packet_channel;
            if (raw == RAW_LEN_INVALID) begin
              res_valid = 1'b1;
              res.kind  = KIND_BAD_LENGTH;
            end else if (plen == 15'd0) begin
              res_valid = 1'b1;
              res.kind  = KIND_NULL_HEADER;
            end else if (plen < HEADER_BYTES || plen_m4 > max_payload) begin
              res_valid = 1'b1;
              res.kind  = KIND_BAD_LENGTH;
            end else begin
              payload_length_next = plen_m4;
              if (plen_m4 == 15'd0) begin
                res_valid = 1'b1;
                res.kind  = KIND_OTHER;
              end else begin
                ignore_rest_next = 1'b0;
              end
            end
          end
        endcase
      end else begin
        byte_position_next = pos + 15'd1;

        if (p == 15'd0) begin
          report_id_next = b;
          if (packet_channel == CH_ERROR && b == RID_ERROR_LIST) begin
            captured_errors_next = '0;
          end
        end
        if (p == POS_SUB_REPORT) begin
          sub_report_id_next = b;
        end
        if (p == POS_RESET_CAUSE && packet_channel == CH_PRODUCT &&
            report_id == RID_PRODUCT_ID_RESP) begin
          captured_reset_cause_next = b;
        end
        if (p == POS_ACCURACY) begin
          captured_accuracy_next = b[1:0];
        end
        if (p >= POS_AXIS_FIRST && p <= POS_AXIS_LAST) begin
          axis_accumulator_next[lane*8 +: 8] = b;
        end

        is_err = packet_channel_next == CH_ERROR && report_id_next == RID_ERROR_LIST;
        entry  = is_err && p != 15'd0 &&
                 EXT_W'(captured_errors_next) < EXT_W'(ERROR_LIST_DEPTH);
        idx_ext = EXT_W'(captured_errors_next);
        if (entry) begin
          captured_errors_next = captured_errors_next + CNT_W'(1);
        end
        cnt_ext = EXT_W'(captured_errors_next);
        res.channel = packet_channel;

        if (!last) begin
          if (entry) begin
            res_valid       = 1'b1;
            res.kind        = KIND_ERROR_ENTRY;
            res.error_index = idx_ext[3:0];
            res.error_code  = b;
          end
        end else begin
          ignore_rest_next = 1'b1;
          res_valid        = 1'b1;
          if (packet_channel == CH_PRODUCT && payload_length >= PROD_MIN_PAYLOAD &&
              report_id_next == RID_PRODUCT_ID_RESP) begin
            res.kind        = KIND_PRODUCT_ID;
            res.reset_cause = captured_reset_cause_next;
          end else if (is_err) begin
            // The last byte, when captured as an entry, rides in the summary item.
            res.kind        = KIND_ERROR_DONE;
            res.error_count = cnt_ext[4:0];
            if (entry) begin
              res.error_index = idx_ext[3:0];
              res.error_code  = b;
            end
          end else if (packet_channel == CH_REPORT && payload_length >= MAG_MIN_PAYLOAD &&
                       report_id_next == RID_TIMEBASE &&
                       sub_report_id_next == SUB_MAG_CALIBRATED) begin
            res.kind         = KIND_MAG_REPORT;
            res.mag_accuracy = captured_accuracy_next;
            res.mag_x        = axis_accumulator_next[15:0];
            res.mag_y        = axis_accumulator_next[31:16];
            res.mag_z        = axis_accumulator_next[47:32];
          end else begin
            res.kind = KIND_OTHER;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= MAX_PAYLOAD_RESET;
    end else if (cfg_we) begin
      max_payload <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position        <= '0;
      payload_length       <= '0;
      length_low_byte      <= '0;
      packet_channel       <= '0;
      report_id            <= '0;
      sub_report_id        <= '0;
      ignore_rest          <= 1'b1;
      captured_reset_cause <= '0;
      captured_errors      <= '0;
      axis_accumulator     <= '0;
      captured_accuracy    <= '0;
    end else if (accept) begin
      byte_position        <= byte_position_next;
      payload_length       <= payload_length_next;
      length_low_byte      <= length_low_byte_next;
      packet_channel       <= packet_channel_next;
      report_id            <= report_id_next;
      sub_report_id        <= sub_report_id_next;
      ignore_rest          <= ignore_rest_next;
      captured_reset_cause <= captured_reset_cause_next;
      captured_errors      <= captured_errors_next;
      axis_accumulator     <= axis_accumulator_next;
      captured_accuracy    <= captured_accuracy_next;
    end
  end

  // Result register plus one skid entry; the skid always holds the younger item.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || out_ready) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= accept && res_valid;
        end
      end else if (accept && res_valid) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_item <= skid_item;
      end else if (accept && res_valid) begin
        out_item <= res;
      end
    end else if (accept && res_valid) begin
      skid_item <= res;
    end
  end

endmodule
